/* hdl/imps_pkg.sv */
package imps_pkg;

  localparam int TABLE_ENTRIES   = 16;
  localparam int STEPS_PER_MACRO = 32;
  localparam int STORE_DEPTH     = TABLE_ENTRIES * STEPS_PER_MACRO;

  localparam int EW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;   // entry index
  localparam int CW  = $clog2(TABLE_ENTRIES + 1);                          // entry count
  localparam int PW  = $clog2(STEPS_PER_MACRO + 1);                        // step count
  localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;        // store address
  localparam int SW  = 51;                                                 // stored step

  localparam int STEP_COUNT_W = 6;

  typedef enum logic [2:0] {
    ACT_POLL    = 3'd0,
    ACT_EXECUTE = 3'd1,
    ACT_ADD     = 3'd2,
    ACT_WRITE   = 3'd3,
    ACT_REMOVE  = 3'd4,
    ACT_CLEAR   = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    KIND_KEY_PRESS   = 3'd0,
    KIND_KEY_RELEASE = 3'd1,
    KIND_MOUSE_MOVE  = 3'd2,
    KIND_BTN_PRESS   = 3'd3,
    KIND_BTN_RELEASE = 3'd4,
    KIND_DELAY       = 3'd5
  } step_kind_t;

  localparam logic [1:0] REPORT_NONE  = 2'd0;
  localparam logic [1:0] REPORT_KEY   = 2'd1;
  localparam logic [1:0] REPORT_MOUSE = 2'd2;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [SW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } ram_ctl_t;

endpackage

/* hdl/imps_step_ram.sv */
module imps_step_ram (
  input  logic                        clk,
  input  imps_pkg::ram_ctl_t          ctl,
  output logic [imps_pkg::SW-1:0]     rdata
);

  logic [imps_pkg::SW-1:0] mem [imps_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rdata <= mem[ctl.raddr];
    end
  end

endmodule

/* hdl/input_macro_playback_sequencer.sv */
// Channel   Dir  tdata (low bit up)                                     tuser
// s_axis    in   target 8, step_count 6, step_index 5, step_kind 3,    action 3
//                param_word 32, param_x 8, param_y 8, now_ms 32, pad 2
// m_axis    out  ok 1, key_count 1, keycode 8, mouse_buttons 8,        report_kind 2
//                mouse_dx 8, mouse_dy 8, finished 1, busy_res 1, pad 4
//
// One beat in, one beat out. Most beats cost a linear id search over the table
// (one entry per cycle); poll adds one step store read. Remove shifts the rows
// above the hit down, a row at a time, through the single write / single read
// step store.
// s_tready is high only when idle and the result register is empty.
// rst is synchronous and clears control state; the step store is not cleared.
module input_macro_playback_sequencer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // target, step_count, step_index, step_kind,
                                  // param_word, param_x, param_y, now_ms
  input  logic [2:0]   s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,   // ok, key_count, keycode, mouse_buttons,
                                  // mouse_dx, mouse_dy, finished, busy_res
  output logic [1:0]   m_tuser    // report_kind
);

  localparam int EW  = imps_pkg::EW;
  localparam int CW  = imps_pkg::CW;
  localparam int PW  = imps_pkg::PW;
  localparam int AW  = imps_pkg::AW;
  localparam int SW  = imps_pkg::SW;
  localparam int TE  = imps_pkg::TABLE_ENTRIES;
  localparam int SPM = imps_pkg::STEPS_PER_MACRO;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_DECIDE, S_STEP, S_COPY, S_OUT
  } state_t;

  state_t state;

  // latched beat
  logic [2:0]  act;
  logic [7:0]  in_id;
  logic [5:0]  in_count;
  logic [4:0]  in_index;
  logic [SW-1:0] in_step;
  logic [31:0] in_now;

  // table
  logic [7:0]    entry_ids   [TE];
  logic [PW-1:0] entry_counts[TE];
  logic [CW-1:0] entry_count;

  // playback
  logic        running;
  logic [7:0]  running_id;
  logic [PW-1:0] step_position;
  logic [31:0] step_started_ms;

  // search / copy
  logic [CW-1:0] sidx;
  logic          found;
  logic [EW-1:0] hit;
  logic [EW-1:0] row;
  logic [PW-1:0] col;

  // result
  logic       r_ok, r_key_count, r_finished, r_busy;
  logic [1:0] r_kind;
  logic [7:0] r_keycode, r_buttons, r_dx, r_dy;

  imps_pkg::ram_ctl_t ram_ctl;
  logic [SW-1:0]      ram_rdata;

  imps_step_ram u_ram (.clk(clk), .ctl(ram_ctl), .rdata(ram_rdata));

  logic [7:0]    key;
  logic [PW-1:0] hit_count;
  logic [PW-1:0] sat_count;
  logic [2:0]    st_kind;
  logic [31:0]   st_prm;

  assign key       = (act == imps_pkg::ACT_POLL) ? running_id : in_id;
  assign hit_count = entry_counts[hit];
  assign sat_count = (in_count > imps_pkg::STEP_COUNT_W'(SPM)) ? PW'(SPM) : PW'(in_count);
  assign st_kind   = ram_rdata[2:0];
  assign st_prm    = ram_rdata[34:3];

  always_comb begin
    ram_ctl       = '0;
    ram_ctl.wdata = in_step;
    if (state == S_DECIDE && act == imps_pkg::ACT_WRITE && found &&
        PW'(in_index) < hit_count) begin
      ram_ctl.we    = 1'b1;
      ram_ctl.waddr = AW'(hit * SPM + PW'(in_index));
    end
    if (state == S_DECIDE && act == imps_pkg::ACT_POLL) begin
      ram_ctl.re    = 1'b1;
      ram_ctl.raddr = AW'(hit * SPM + step_position);
    end
    if (state == S_COPY) begin
      if (col < PW'(SPM)) begin
        ram_ctl.re    = 1'b1;
        ram_ctl.raddr = AW'((row + 1) * SPM + col);
      end
      if (col != '0) begin
        ram_ctl.we    = 1'b1;
        ram_ctl.waddr = AW'(row * SPM + col - 1);
        ram_ctl.wdata = ram_rdata;
      end
    end
  end

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign m_tdata  = {4'd0, r_busy, r_finished, r_dy, r_dx, r_buttons, r_keycode,
                     r_key_count, r_ok};
  assign m_tuser  = r_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_tvalid        <= 1'b0;
      entry_count     <= '0;
      running         <= 1'b0;
      running_id      <= '0;
      step_position   <= '0;
      step_started_ms <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            act      <= s_tuser;
            in_id    <= s_tdata[7:0];
            in_count <= s_tdata[13:8];
            in_index <= s_tdata[18:14];
            in_step  <= {s_tdata[69:54], s_tdata[53:22], s_tdata[21:19]};
            in_now   <= s_tdata[101:70];
            r_ok <= (s_tuser == imps_pkg::ACT_CLEAR);
            r_key_count <= 1'b0; r_finished <= 1'b0;
            r_kind <= imps_pkg::REPORT_NONE;
            r_keycode <= '0; r_buttons <= '0; r_dx <= '0; r_dy <= '0;
            sidx  <= '0;
            found <= 1'b0;
            case (s_tuser)
              imps_pkg::ACT_POLL:    state <= running ? S_SEARCH : S_OUT;
              imps_pkg::ACT_EXECUTE,
              imps_pkg::ACT_WRITE,
              imps_pkg::ACT_REMOVE:  state <= S_SEARCH;
              imps_pkg::ACT_ADD:     state <= (entry_count < CW'(TE)) ? S_SEARCH : S_OUT;
              imps_pkg::ACT_CLEAR: begin
                entry_count <= '0;
                state       <= S_OUT;
              end
              default:               state <= S_OUT;
            endcase
          end
        end
        S_SEARCH: begin
          if (sidx == entry_count) begin
            hit   <= EW'(entry_count);
            state <= S_DECIDE;
          end else if (entry_ids[sidx[EW-1:0]] == key) begin
            found <= 1'b1;
            hit   <= sidx[EW-1:0];
            state <= S_DECIDE;
          end else begin
            sidx <= sidx + 1'b1;
          end
        end
        S_DECIDE: begin
          case (act)
            imps_pkg::ACT_POLL: begin
              if (!found || step_position >= hit_count) begin
                running    <= 1'b0;
                r_finished <= 1'b1;
                state      <= S_OUT;
              end else begin
                state <= S_STEP;
              end
            end
            imps_pkg::ACT_EXECUTE: begin
              if (found && !running) begin
                running         <= 1'b1;
                running_id      <= in_id;
                step_position   <= '0;
                step_started_ms <= in_now;
                r_ok            <= 1'b1;
              end
              state <= S_OUT;
            end
            imps_pkg::ACT_ADD: begin
              entry_ids[hit]    <= in_id;
              entry_counts[hit] <= sat_count;
              if (!found) begin
                entry_count <= entry_count + 1'b1;
              end
              r_ok  <= 1'b1;
              state <= S_OUT;
            end
            imps_pkg::ACT_WRITE: begin
              r_ok  <= found && (PW'(in_index) < hit_count);
              state <= S_OUT;
            end
            imps_pkg::ACT_REMOVE: begin
              if (found) begin
                r_ok <= 1'b1;
                if (CW'(hit) + 1'b1 < entry_count) begin
                  row   <= hit;
                  col   <= '0;
                  state <= S_COPY;
                end else begin
                  entry_count <= entry_count - 1'b1;
                  state       <= S_OUT;
                end
              end else begin
                state <= S_OUT;
              end
            end
            default: state <= S_OUT;
          endcase
        end
        S_STEP: begin
          state <= S_OUT;
          case (st_kind)
            imps_pkg::KIND_KEY_PRESS: begin
              r_kind <= imps_pkg::REPORT_KEY; r_key_count <= 1'b1;
              r_keycode <= st_prm[7:0];
            end
            imps_pkg::KIND_KEY_RELEASE: r_kind <= imps_pkg::REPORT_KEY;
            imps_pkg::KIND_MOUSE_MOVE: begin
              r_kind <= imps_pkg::REPORT_MOUSE;
              r_dx <= ram_rdata[42:35]; r_dy <= ram_rdata[50:43];
            end
            imps_pkg::KIND_BTN_PRESS: begin
              r_kind <= imps_pkg::REPORT_MOUSE; r_buttons <= st_prm[7:0];
            end
            imps_pkg::KIND_BTN_RELEASE: r_kind <= imps_pkg::REPORT_MOUSE;
            default: ;
          endcase
          if (st_kind == imps_pkg::KIND_DELAY) begin
            if ((in_now - step_started_ms) >= st_prm) begin
              step_position   <= step_position + 1'b1;
              step_started_ms <= in_now;
            end
          end else begin
            step_position <= step_position + 1'b1;
            if (st_kind <= imps_pkg::KIND_BTN_RELEASE) begin
              step_started_ms <= in_now;
            end
          end
        end
        S_COPY: begin
          // read pipeline: column col is read while col-1 is written
          if (col == PW'(SPM)) begin
            entry_ids[row]    <= entry_ids[row + 1'b1];
            entry_counts[row] <= entry_counts[row + 1'b1];
            if (CW'(row) + 2'd2 < entry_count) begin
              row <= row + 1'b1;
              col <= '0;
            end else begin
              entry_count <= entry_count - 1'b1;
              state       <= S_OUT;
            end
          end else begin
            col <= col + 1'b1;
          end
        end
        S_OUT: begin
          r_busy   <= running;
          m_tvalid <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_in_gate: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid && state == S_IDLE) else $error("accept while busy");
  a_count: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TE)) else $error("entry count overflow");
  a_finish: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r_finished |-> !r_busy && !r_ok) else $error("finish with busy");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> r_kind <= imps_pkg::REPORT_MOUSE) else $error("bad report kind");
`endif

endmodule
